### rtl/pcavg_pkg.sv
// Shared constants and types for the per-track colour averager.
package pcavg_pkg;

	// Parameter defaults
	localparam int TRACK_COUNT_DEF = 1024;
	localparam int COUNT_BITS_DEF  = 16;

	// Fixed field widths
	localparam int IDX_W    = 10;
	localparam int CHAN_W   = 8;
	localparam int SEEN_W   = 16;
	localparam int NCH      = 3;
	localparam int QUO_BITS = 8;

	// Divider status seen by the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

### rtl/pcavg_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pcavg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

### rtl/pcavg_div_unit.sv
// Restoring divider, one quotient bit per cycle, 8-bit quotient.
module pcavg_div_unit #(
	parameter int NW = 26
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [NW-1:0]                    num,
	input  logic [NW-1:0]                    den,
	output pcavg_pkg::div_stat_t             stat,
	output logic [pcavg_pkg::QUO_BITS-1:0]   quo
);

	localparam int QB  = pcavg_pkg::QUO_BITS;
	localparam int STW = $clog2(QB);

	logic [NW-1:0]  rem_q;
	logic [NW-1:0]  dsh_q;
	logic [QB-1:0]  quo_q;
	logic [STW-1:0] step_q;
	logic           busy_q;
	logic           ge;
	logic [NW-1:0]  diff;

	// shared compare / subtract
	assign ge   = rem_q >= dsh_q;
	assign diff = rem_q - dsh_q;

	assign stat.busy = busy_q;
	assign stat.done = busy_q && (step_q == '0);
	assign quo       = {quo_q[QB-2:0], ge};

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= STW'(QB - 1);
		end else if (busy_q) begin
			if (step_q == '0) begin
				busy_q <= 1'b0;
			end
			step_q <= step_q - 1'b1;
		end
	end

	// datapath: den arrives already aligned to the top quotient bit
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			dsh_q <= den;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= diff;
			end
			dsh_q <= dsh_q >> 1;
			quo_q <= {quo_q[QB-2:0], ge};
		end
	end

endmodule

### rtl/per_track_colour_averager.sv
// Top level: per-track RGB sum store, sequencer and shared mean divider.
//
//  channel  | valid         | ready         | payload
//  ---------+---------------+---------------+----------------------------------------------
//  item     | item_valid    | item_ready    | mode track_id red green blue sample_valid
//  result   | result_valid  | result_ready  | mean_red mean_green mean_blue has_colour
//           |               |               | count_seen dropped
//
// After reset a clearing pass writes zero to all TRACK_COUNT entries.
// Accept to next accept: a sample is read and updated, then finishes; an index out of range
// goes straight to finish; a readout of a nonempty track runs the single divider per channel
// (load plus one quotient bit per cycle) for three channels, plus read and finish.
// A finished result waits in the output register; a new transaction is accepted meanwhile,
// and the sequencer only holds at its last step while that register is occupied and not taken.
module per_track_colour_averager #(
	parameter int TRACK_COUNT = pcavg_pkg::TRACK_COUNT_DEF,
	parameter int COUNT_BITS  = pcavg_pkg::COUNT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_ready,
	input  logic                          mode,
	input  logic [pcavg_pkg::IDX_W-1:0]   track_id,
	input  logic [pcavg_pkg::CHAN_W-1:0]  red,
	input  logic [pcavg_pkg::CHAN_W-1:0]  green,
	input  logic [pcavg_pkg::CHAN_W-1:0]  blue,
	input  logic                          sample_valid,
	output logic                          result_valid,
	input  logic                          result_ready,
	output logic [pcavg_pkg::CHAN_W-1:0]  mean_red,
	output logic [pcavg_pkg::CHAN_W-1:0]  mean_green,
	output logic [pcavg_pkg::CHAN_W-1:0]  mean_blue,
	output logic                          has_colour,
	output logic [pcavg_pkg::SEEN_W-1:0]  count_seen,
	output logic                          dropped
);

	localparam int CW  = pcavg_pkg::CHAN_W;
	localparam int NCH = pcavg_pkg::NCH;
	localparam int AW  = $clog2(TRACK_COUNT);
	localparam int SW  = COUNT_BITS + CW;
	localparam int EW  = NCH * SW + COUNT_BITS;
	localparam int NW  = SW + 2;

	typedef enum logic [4:0] {
		ST_CLEAR  = 5'b00001,
		ST_IDLE   = 5'b00010,
		ST_READ   = 5'b00100,
		ST_DIV    = 5'b01000,
		ST_FINISH = 5'b10000
	} state_t;

	state_t                state_q;
	logic [AW-1:0]         clr_q;
	logic [1:0]            ch_q;
	logic                  mode_q;
	logic                  valid_q;
	logic [AW-1:0]         addr_q;
	logic [CW-1:0]         smp_q [NCH];
	logic [SW-1:0]         sum_q [NCH];
	logic [COUNT_BITS-1:0] cnt_q;
	logic [CW-1:0]         res_mean_q [NCH];
	logic                  res_has_q;
	logic [15:0]           res_cnt_q;
	logic                  res_drop_q;
	logic                  out_valid_q;
	logic [CW-1:0]         out_mean_q [NCH];
	logic                  out_has_q;
	logic [15:0]           out_cnt_q;
	logic                  out_drop_q;

	logic                  accept;
	logic                  in_range;
	logic [AW-1:0]         addr_in;
	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	logic [EW-1:0]         ram_wdata;
	logic [EW-1:0]         ram_rdata;
	logic [COUNT_BITS-1:0] rd_cnt;
	logic [SW-1:0]         rd_sum [NCH];
	logic [EW-1:0]         upd_data;
	logic                  rd_full;
	logic                  do_add;
	logic                  out_load;
	logic                  div_start;
	logic [NW-1:0]         div_num;
	logic [NW-1:0]         div_den;
	logic [CW-1:0]         div_quo;
	pcavg_pkg::div_stat_t  div_stat;

	assign item_ready = (state_q == ST_IDLE);
	assign accept     = item_valid && item_ready;
	assign in_range   = 32'(track_id) < 32'(TRACK_COUNT);
	assign addr_in    = AW'(track_id);

	// entry unpack and sample update
	always_comb begin
		rd_cnt   = ram_rdata[EW-1 -: COUNT_BITS];
		upd_data = '0;
		for (int c = 0; c < NCH; c++) begin
			rd_sum[c] = ram_rdata[c*SW +: SW];
			upd_data[c*SW +: SW] = rd_sum[c] + SW'(smp_q[c]);
		end
		upd_data[EW-1 -: COUNT_BITS] = rd_cnt + 1'b1;
	end

	assign rd_full = (rd_cnt == '1);
	assign do_add  = !mode_q && valid_q && !rd_full;

	// store write port: clearing pass, sample update or readout clear
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = '0;
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
		end else if (state_q == ST_READ) begin
			ram_we    = mode_q || do_add;
			ram_wdata = mode_q ? '0 : upd_data;
		end
	end

	pcavg_ram #(
		.WIDTH(EW),
		.DEPTH(TRACK_COUNT)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(addr_in),
		.rdata(ram_rdata)
	);

	// divider operands: (2*sum + cnt) / (2*cnt), divisor aligned to quotient bit 7
	assign div_start = (state_q == ST_DIV) && !div_stat.busy;
	assign div_num   = NW'({sum_q[ch_q], 1'b0}) + NW'(cnt_q);
	assign div_den   = NW'({cnt_q, 8'b0});

	pcavg_div_unit #(
		.NW(NW)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.stat  (div_stat),
		.quo   (div_quo)
	);

	assign out_load = (state_q == ST_FINISH) && (!out_valid_q || result_ready);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			ch_q    <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(TRACK_COUNT - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= in_range ? ST_READ : ST_FINISH;
					end
				end
				ST_READ: begin
					ch_q    <= '0;
					state_q <= (mode_q && rd_cnt != '0) ? ST_DIV : ST_FINISH;
				end
				ST_DIV: begin
					if (div_stat.done) begin
						if (ch_q == 2'(NCH - 1)) begin
							state_q <= ST_FINISH;
						end else begin
							ch_q <= ch_q + 1'b1;
						end
					end
				end
				ST_FINISH: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

	// transaction capture, entry latch and result build
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q     <= mode;
			valid_q    <= sample_valid;
			addr_q     <= addr_in;
			smp_q[0]   <= red;
			smp_q[1]   <= green;
			smp_q[2]   <= blue;
			res_has_q  <= 1'b0;
			res_cnt_q  <= '0;
			res_drop_q <= 1'b0;
			for (int c = 0; c < NCH; c++) begin
				res_mean_q[c] <= '0;
			end
		end
		if (state_q == ST_READ) begin
			cnt_q      <= rd_cnt;
			for (int c = 0; c < NCH; c++) begin
				sum_q[c] <= rd_sum[c];
			end
			res_has_q  <= mode_q && (rd_cnt != '0);
			res_drop_q <= !mode_q && valid_q && rd_full;
			res_cnt_q  <= do_add ? 16'(rd_cnt + 1'b1) : 16'(rd_cnt);
		end
		if ((state_q == ST_DIV) && div_stat.done) begin
			res_mean_q[ch_q] <= div_quo;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			for (int c = 0; c < NCH; c++) begin
				out_mean_q[c] <= res_mean_q[c];
			end
			out_has_q  <= res_has_q;
			out_cnt_q  <= res_cnt_q;
			out_drop_q <= res_drop_q;
		end
	end

	assign result_valid = out_valid_q;
	assign mean_red     = out_mean_q[0];
	assign mean_green   = out_mean_q[1];
	assign mean_blue    = out_mean_q[2];
	assign has_colour   = out_has_q;
	assign count_seen   = out_cnt_q;
	assign dropped      = out_drop_q;

endmodule

### rtl/pcavg_chk.sv
// Port-level checks for the per-track colour averager, bound to the top level.
module pcavg_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          item_valid,
	input logic                          item_ready,
	input logic                          result_valid,
	input logic                          result_ready,
	input logic [pcavg_pkg::CHAN_W-1:0]  mean_red,
	input logic [pcavg_pkg::CHAN_W-1:0]  mean_green,
	input logic [pcavg_pkg::CHAN_W-1:0]  mean_blue,
	input logic                          has_colour,
	input logic [pcavg_pkg::SEEN_W-1:0]  count_seen,
	input logic                          dropped
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(mean_red)
		&& $stable(mean_green) && $stable(mean_blue) && $stable(has_colour)
		&& $stable(count_seen) && $stable(dropped))
		else $error("result changed while stalled");

	// no colour means zero means
	a_no_colour: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !has_colour |-> mean_red == '0 && mean_green == '0
		&& mean_blue == '0)
		else $error("nonzero mean without colour");

	// a dropped sample is an accumulate, never a readout
	a_drop_excl: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && dropped |-> !has_colour)
		else $error("dropped and has_colour together");

	// one transaction at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("ready right after accept");

endmodule

bind per_track_colour_averager pcavg_chk u_pcavg_chk (.*);
